// ----- rtl/core/ttm_pkg.sv -----
// Shared types, constants and the quarter-wave sine table for the test tone mixer.
// No dependencies; every other file of the block imports it.
package ttm_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QUARTER_LEN     = 1 << QUARTER_BITS;
   localparam int DECAY_BITS      = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;
   localparam int STEP_BITS       = (PHASE_BITS < CSR_DATA_BITS) ? PHASE_BITS : CSR_DATA_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP     = 2'd0,
      CSR_INPUT_CHANNELS = 2'd1,
      CSR_DECAY_FACTOR   = 2'd2
   } csr_index_type;

   // channel select codes; the unused code behaves as both
   typedef enum logic [1:0] {
      CH_NONE = 2'd0,
      CH_LEFT = 2'd1,
      CH_BOTH = 2'd2
   } channel_code_type;

   localparam logic [CSR_DATA_BITS-1:0] PHASE_STEP_RESET = 32'd89478485;
   localparam logic [1:0]               CHANNELS_RESET   = CH_BOTH;
   localparam logic [DECAY_BITS-1:0]    DECAY_RESET      = 16'd55706;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SAMPLE_BITS-1:0]        level_type;
   typedef logic [SAMPLE_BITS-2:0]        sine_mag_type;
   typedef sine_mag_type                  sine_table_type [QUARTER_LEN];

   typedef struct packed {
      sample_type left;
      sample_type right;
      sample_type tone;
      logic       last;
   } frame_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      level_type  meter_left;
      level_type  meter_right;
      logic       meter_valid;
   } result_type;

   localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
   localparam logic [63:0] Q30_ONE    = 64'd1073741824;
   localparam logic [63:0] SC1        = 64'd1686629713;
   localparam logic [63:0] SC3        = 64'd693598668;
   localparam logic [63:0] SC5        = 64'd85569306;
   localparam logic [63:0] SC7        = 64'd5026995;
   localparam logic [63:0] SC9        = 64'd172273;
   localparam logic [63:0] SC11       = 64'd3864;

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] prod;
      prod = a * b;
      return prod >> 30;
   endfunction

   // odd polynomial through x^11 on a quarter wave, scaled to the sample range
   function automatic sine_mag_type sine_mag(input int j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] m;
      x  = 64'(j) << (30 - QUARTER_BITS);
      x2 = qmul(x, x);
      p  = SC9 - qmul(x2, SC11);
      p  = SC7 - qmul(x2, p);
      p  = SC5 - qmul(x2, p);
      p  = SC3 - qmul(x2, p);
      p  = SC1 - qmul(x2, p);
      s  = qmul(x, p);
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      m = (s * (FULL_SCALE - 64'd1) + (Q30_ONE >> 1)) >> 30;
      return m[SAMPLE_BITS-2:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int k = 0; k < QUARTER_LEN; k++) begin
         t[k] = sine_mag(k);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   // quarter-wave point at exactly pi/2, one past the table
   localparam sine_mag_type   SINE_PEAK  = sine_mag(QUARTER_LEN);

endpackage

// ----- rtl/core/test_tone_mixer_peak_meter_core.sv -----
// Test tone mixer with peak meter: two register stages, one frame per cycle unless stalled.
// An accepted request is registered in s1_ff, then in rsp_ff, which drives rsp_tvalid.
// One request per cycle unless stalled; phase add and meter update each close in one stage.
// Reset clears phase, peaks, meters and both valid stages; registers return to defaults.
// A stalled response holds; req_tready stays high while the output can drain.
// Depends on ttm_pkg, ttm_tone and ttm_mix_meter.
module test_tone_mixer_peak_meter_core import ttm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*SAMPLE_BITS-1:0]  req_tdata,   // left_in, right_in
   input  logic                      req_tlast,   // block_last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [4*SAMPLE_BITS-1:0]  rsp_tdata,   // left_out, right_out, meter_left_out,
                                                  // meter_right_out
   output logic                      rsp_tuser,   // meter_valid
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [CSR_DATA_BITS-1:0] phase_step_ff, phase_step_in;
   logic [1:0]               channels_ff, channels_in;
   logic [DECAY_BITS-1:0]    decay_ff, decay_in;

   frame_type  s1_ff, s1_in;
   logic       s1_valid_ff, s1_valid_in;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       req_fire;
   logic       s1_adv;
   sample_type tone;
   result_type mix_result;

   ttm_tone u_tone (
      .clock      (clock),
      .reset      (reset),
      .phase_step (phase_step_ff),
      .advance    (req_fire),
      .tone       (tone)
   );

   ttm_mix_meter u_mix_meter (
      .clock        (clock),
      .reset        (reset),
      .frame        (s1_ff),
      .advance      (s1_adv),
      .decay_factor (decay_ff),
      .result       (mix_result)
   );

   always_comb begin
      csr_ready  = 1'b1;
      req_tready = !s1_valid_ff || !rsp_valid_ff || rsp_tready;
      req_fire   = req_tvalid && req_tready;
      s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);

      phase_step_in = phase_step_ff;
      channels_in   = channels_ff;
      decay_in      = decay_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PHASE_STEP:     phase_step_in = csr_data;
            CSR_INPUT_CHANNELS: channels_in   = csr_data[1:0];
            CSR_DECAY_FACTOR:   decay_in      = csr_data[DECAY_BITS-1:0];
            default:            ;
         endcase
      end

      s1_in.left  = (channels_ff != CH_NONE) ? sample_type'(req_tdata[SAMPLE_BITS-1:0]) : '0;
      s1_in.right = (channels_ff != CH_NONE && channels_ff != CH_LEFT)
                    ? sample_type'(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
      s1_in.tone  = tone;
      s1_in.last  = req_tlast;

      s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

      rsp_in       = mix_result;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {rsp_ff.meter_right, rsp_ff.meter_left, rsp_ff.right, rsp_ff.left};
      rsp_tuser  = rsp_ff.meter_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         channels_ff   <= CHANNELS_RESET;
         decay_ff      <= DECAY_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_step_ff <= phase_step_in;
         channels_ff   <= channels_in;
         decay_ff      <= decay_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/ttm_tone.sv -----
// Tone generator: wrapping phase accumulator and quarter-wave sine lookup.
// Depends on ttm_pkg for widths and the sine table.
module ttm_tone import ttm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CSR_DATA_BITS-1:0] phase_step,
   input  logic                     advance,
   output sample_type               tone
);

   logic [PHASE_BITS-1:0]      phase_ff;
   logic [PHASE_BITS-1:0]      phase_in;
   logic [SINE_TABLE_BITS-1:0] addr;
   logic [QUARTER_BITS-1:0]    j;
   logic [QUARTER_BITS-1:0]    idx;
   sine_mag_type               mag;

   always_comb begin
      addr = phase_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
      j    = addr[QUARTER_BITS-1:0];
      // odd quadrants run the quarter wave backwards
      idx  = addr[QUARTER_BITS] ? (~j + QUARTER_BITS'(1)) : j;
      if (addr[QUARTER_BITS] && (j == '0)) begin
         mag = SINE_PEAK;
      end else begin
         mag = SINE_TABLE[idx];
      end
      tone = addr[SINE_TABLE_BITS-1] ? sample_type'(-$signed({1'b0, mag}))
                                     : sample_type'({1'b0, mag});
      phase_in = advance ? phase_ff + PHASE_BITS'(phase_step[STEP_BITS-1:0]) : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- rtl/core/ttm_mix_meter.sv -----
// Mixer and meter: tone add with saturation, block peak tracking, decaying meters.
// Depends on ttm_pkg for the frame and result structs.
module ttm_mix_meter import ttm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  frame_type             frame,
   input  logic                  advance,
   input  logic [DECAY_BITS-1:0] decay_factor,
   output result_type            result
);

   localparam int PROD_BITS = SAMPLE_BITS + DECAY_BITS;

   level_type                     peak_l_ff, peak_l_in, peak_r_ff, peak_r_in;
   level_type                     meter_l_ff, meter_l_in, meter_r_ff, meter_r_in;
   logic signed [SAMPLE_BITS:0]   sum_l, sum_r;
   sample_type                    sat_l, sat_r;
   level_type                     mag_l, mag_r, peak_l_max, peak_r_max;
   logic [PROD_BITS-1:0]          prod_l, prod_r;
   level_type                     decay_l, decay_r, upd_l, upd_r;

   function automatic sample_type saturate(input logic signed [SAMPLE_BITS:0] v);
      sample_type r;
      if (v[SAMPLE_BITS] == v[SAMPLE_BITS-1]) begin
         r = v[SAMPLE_BITS-1:0];
      end else if (!v[SAMPLE_BITS]) begin
         r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
      return r;
   endfunction

   // most negative sample maps to exactly full scale
   function automatic level_type magnitude(input sample_type v);
      return v[SAMPLE_BITS-1] ? level_type'(-v) : level_type'(v);
   endfunction

   always_comb begin
      sum_l = (SAMPLE_BITS+1)'(frame.left) + (SAMPLE_BITS+1)'(frame.tone);
      sum_r = (SAMPLE_BITS+1)'(frame.right) + (SAMPLE_BITS+1)'(frame.tone);
      sat_l = saturate(sum_l);
      sat_r = saturate(sum_r);
      mag_l = magnitude(sat_l);
      mag_r = magnitude(sat_r);
      peak_l_max = (mag_l > peak_l_ff) ? mag_l : peak_l_ff;
      peak_r_max = (mag_r > peak_r_ff) ? mag_r : peak_r_ff;

      prod_l  = PROD_BITS'(meter_l_ff) * PROD_BITS'(decay_factor);
      prod_r  = PROD_BITS'(meter_r_ff) * PROD_BITS'(decay_factor);
      decay_l = prod_l[PROD_BITS-1:DECAY_BITS];
      decay_r = prod_r[PROD_BITS-1:DECAY_BITS];
      upd_l   = (peak_l_max > decay_l) ? peak_l_max : decay_l;
      upd_r   = (peak_r_max > decay_r) ? peak_r_max : decay_r;

      peak_l_in  = peak_l_ff;
      peak_r_in  = peak_r_ff;
      meter_l_in = meter_l_ff;
      meter_r_in = meter_r_ff;
      if (advance) begin
         if (frame.last) begin
            peak_l_in  = '0;
            peak_r_in  = '0;
            meter_l_in = upd_l;
            meter_r_in = upd_r;
         end else begin
            peak_l_in = peak_l_max;
            peak_r_in = peak_r_max;
         end
      end

      result.left        = sat_l;
      result.right       = sat_r;
      result.meter_left  = frame.last ? upd_l : meter_l_ff;
      result.meter_right = frame.last ? upd_r : meter_r_ff;
      result.meter_valid = frame.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_l_ff  <= '0;
         peak_r_ff  <= '0;
         meter_l_ff <= '0;
         meter_r_ff <= '0;
      end else begin
         peak_l_ff  <= peak_l_in;
         peak_r_ff  <= peak_r_in;
         meter_l_ff <= meter_l_in;
         meter_r_ff <= meter_r_in;
      end
   end

endmodule

// ----- rtl/core/ttm_checker.sv -----
// Port-level checks for the test tone mixer core, bound to the top level.
// Depends on ttm_pkg and test_tone_mixer_peak_meter_core.
module ttm_checker import ttm_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [4*SAMPLE_BITS-1:0] rsp_tdata
);

   localparam level_type FULL_LEVEL = level_type'(FULL_SCALE);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a fresh response comes from an accepted request registered through both stages
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without matching request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS] <= FULL_LEVEL) &&
                     (rsp_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS] <= FULL_LEVEL))
      else $error("meter above full scale");

endmodule

bind test_tone_mixer_peak_meter_core ttm_checker u_ttm_checker (.*);
